/* rtl/core/ucrm_pkg.sv */
// ---------------------------------------------------------------------------
// ucrm_pkg
// Shared types and constants for the case-range mapper: field widths,
// action and case codes, character bounds and the table entry layout.
// ---------------------------------------------------------------------------
package ucrm_pkg;

   localparam int CP_W    = 21;
   localparam int DELTA_W = 22;
   localparam int COUNT_W = 10;
   localparam int INDEX_W = 9;
   localparam int CASE_W  = 2;

   // Item actions
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // Case selector codes
   localparam logic [CASE_W-1:0] CASE_UPPER   = 2'd0;
   localparam logic [CASE_W-1:0] CASE_LOWER   = 2'd1;
   localparam logic [CASE_W-1:0] CASE_TITLE   = 2'd2;
   localparam logic [CASE_W-1:0] CASE_INVALID = 2'd3;

   // Code point constants
   localparam logic [CP_W-1:0] MAX_CP       = 21'h10FFFF;
   localparam logic [CP_W-1:0] REPL_CHAR    = 21'h00FFFD;
   localparam logic [CP_W-1:0] ASCII_MAX    = 21'h00007F;
   localparam logic [CP_W-1:0] CHAR_UPPER_A = 21'h000041;
   localparam logic [CP_W-1:0] CHAR_UPPER_Z = 21'h00005A;
   localparam logic [CP_W-1:0] CHAR_LOWER_A = 21'h000061;
   localparam logic [CP_W-1:0] CHAR_LOWER_Z = 21'h00007A;
   localparam logic [CP_W-1:0] ASCII_SHIFT  = 21'h000020;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MAP,
      ST_DONE
   } state_type;

   // One case-range table entry
   typedef struct packed {
      logic [CP_W-1:0]           range_low;
      logic [CP_W-1:0]           range_high;
      logic signed [DELTA_W-1:0] delta_upper;
      logic signed [DELTA_W-1:0] delta_lower;
      logic signed [DELTA_W-1:0] delta_title;
      logic                      alternating_run;
   } entry_type;

endpackage

/* rtl/core/unicode_case_range_mapper.sv */
// ---------------------------------------------------------------------------
// unicode_case_range_mapper
// Simple case mapping (upper, lower, title) of a code point through a
// loadable, sorted table of case ranges, searched by binary search.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_stall   action, load entry, query
//  rsp_      out        rsp_valid/rsp_stall   mapped code point and flags
//  csr_      in         csr_wr_en             entry_count (10 bits)
//
//  A load, and an invalid-case, ASCII or empty-table query, skip the search.
//  A table query runs a binary search with one single-port table read per
//  search step, at most ceil(log2(n+1)) reads for n entries in use; a hit
//  then passes through the map step before its result is done.
//  Reset clears the controller, output valid and entry_count; the table is
//  not cleared. The input stalls while an item is in work; one finished
//  result may wait in the output register while the next item is taken.
//
module unicode_case_range_mapper #(
   parameter int TABLE_DEPTH = 512
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_wr_en,
   input  logic [ucrm_pkg::COUNT_W-1:0]           csr_wr_data,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_action,
   input  logic [ucrm_pkg::INDEX_W-1:0]           req_entry_index,
   input  logic [ucrm_pkg::CP_W-1:0]              req_range_low,
   input  logic [ucrm_pkg::CP_W-1:0]              req_range_high,
   input  logic signed [ucrm_pkg::DELTA_W-1:0]    req_delta_upper,
   input  logic signed [ucrm_pkg::DELTA_W-1:0]    req_delta_lower,
   input  logic signed [ucrm_pkg::DELTA_W-1:0]    req_delta_title,
   input  logic                                   req_alternating_run,
   input  logic [ucrm_pkg::CP_W-1:0]              req_code_point,
   input  logic [ucrm_pkg::CASE_W-1:0]            req_case_select,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ucrm_pkg::CP_W-1:0]              rsp_mapped_code_point,
   output logic                                   rsp_range_hit,
   output logic                                   rsp_bad_case,
   output logic                                   rsp_range_error
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int CP_W   = ucrm_pkg::CP_W;

   // Table memory
   ucrm_pkg::entry_type mem [TABLE_DEPTH];
   ucrm_pkg::entry_type rd_data_ff;
   ucrm_pkg::entry_type wr_data;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;

   // Control state
   ucrm_pkg::state_type          state_ff, state_in;
   logic [ucrm_pkg::COUNT_W-1:0] entry_count_ff;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Search and result payload
   logic [CNT_W-1:0]            lo_ff, lo_in;
   logic [CNT_W-1:0]            hi_ff, hi_in;
   logic [ADDR_W-1:0]           mid_ff, mid_in;
   logic [CP_W-1:0]             cp_ff, cp_in;
   logic [ucrm_pkg::CASE_W-1:0] cs_ff, cs_in;
   logic [CP_W-1:0]             res_cp_ff, res_cp_in;
   logic                        res_hit_ff, res_hit_in;
   logic                        res_bad_ff, res_bad_in;
   logic                        res_err_ff, res_err_in;
   logic [CP_W-1:0]             rsp_cp_ff, rsp_cp_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic                        rsp_bad_ff, rsp_bad_in;
   logic                        rsp_err_ff, rsp_err_in;

   // Helpers
   logic                        req_fire;
   logic                        rsp_free;
   logic [CNT_W-1:0]            n_used;
   logic [CNT_W:0]              next_sum;
   logic [CNT_W-1:0]            next_lo;
   logic [CNT_W-1:0]            next_hi;
   logic [CP_W-1:0]             ascii_cp;
   logic [CP_W-1:0]             run_off;
   logic [CP_W:0]               alt_res;

   logic signed [ucrm_pkg::DELTA_W-1:0] sel_delta;
   logic signed [CP_W+2:0]              delta_res;
   logic                                entry_hit;

   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ucrm_pkg::ST_IDLE);

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_mapped_code_point = rsp_cp_ff;
   assign rsp_range_hit         = rsp_hit_ff;
   assign rsp_bad_case          = rsp_bad_ff;
   assign rsp_range_error       = rsp_err_ff;

   // Saturate the searched count to the table depth
   always_comb begin
      if (32'(entry_count_ff) > 32'(TABLE_DEPTH)) begin
         n_used = CNT_W'(TABLE_DEPTH);
      end else begin
         n_used = CNT_W'(entry_count_ff);
      end
   end

   // ASCII shortcut
   always_comb begin
      ascii_cp = req_code_point;
      if (req_case_select == ucrm_pkg::CASE_LOWER) begin
         if (req_code_point >= ucrm_pkg::CHAR_UPPER_A &&
             req_code_point <= ucrm_pkg::CHAR_UPPER_Z) begin
            ascii_cp = req_code_point + ucrm_pkg::ASCII_SHIFT;
         end
      end else begin
         if (req_code_point >= ucrm_pkg::CHAR_LOWER_A &&
             req_code_point <= ucrm_pkg::CHAR_LOWER_Z) begin
            ascii_cp = req_code_point - ucrm_pkg::ASCII_SHIFT;
         end
      end
   end

   // Compare the fetched entry and narrow the search window
   always_comb begin
      entry_hit = (rd_data_ff.range_low <= cp_ff) && (cp_ff <= rd_data_ff.range_high);
      if (cp_ff < rd_data_ff.range_low) begin
         next_lo = lo_ff;
         next_hi = CNT_W'(mid_ff);
      end else begin
         next_lo = CNT_W'(mid_ff) + CNT_W'(1);
         next_hi = hi_ff;
      end
      next_sum = {1'b0, next_lo} + {1'b0, next_hi};
   end

   // Map through the hit entry (registered entry and query)
   always_comb begin
      run_off = cp_ff - rd_data_ff.range_low;
      alt_res = {1'b0, rd_data_ff.range_low} + {1'b0, run_off[CP_W-1:1], cs_ff[0]};
      case (cs_ff)
         ucrm_pkg::CASE_UPPER: sel_delta = rd_data_ff.delta_upper;
         ucrm_pkg::CASE_LOWER: sel_delta = rd_data_ff.delta_lower;
         default:              sel_delta = rd_data_ff.delta_title;
      endcase
      delta_res = $signed({3'b000, cp_ff}) + $signed({{2{sel_delta[ucrm_pkg::DELTA_W-1]}},
                                                      sel_delta});
   end

   // Next state, table access and result
   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      cp_in        = cp_ff;
      cs_in        = cs_ff;
      res_cp_in    = res_cp_ff;
      res_hit_in   = res_hit_ff;
      res_bad_in   = res_bad_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cp_in    = rsp_cp_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_err_in   = rsp_err_ff;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(req_entry_index);
      wr_data      = '{range_low:       req_range_low,
                       range_high:      req_range_high,
                       delta_upper:     req_delta_upper,
                       delta_lower:     req_delta_lower,
                       delta_title:     req_delta_title,
                       alternating_run: req_alternating_run};
      rd_en        = 1'b0;
      rd_addr      = mid_ff;

      // drop the shown result once it is taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ucrm_pkg::ST_IDLE: begin
            if (req_fire) begin
               res_cp_in  = '0;
               res_hit_in = 1'b0;
               res_bad_in = 1'b0;
               res_err_in = 1'b0;
               cp_in      = req_code_point;
               cs_in      = req_case_select;
               state_in   = ucrm_pkg::ST_DONE;
               if (req_action == ucrm_pkg::ACTION_LOAD) begin
                  wr_en = (32'(req_entry_index) < 32'(TABLE_DEPTH));
               end else if (req_case_select == ucrm_pkg::CASE_INVALID) begin
                  res_cp_in  = ucrm_pkg::REPL_CHAR;
                  res_bad_in = 1'b1;
               end else if (req_code_point <= ucrm_pkg::ASCII_MAX) begin
                  res_cp_in = ascii_cp;
               end else begin
                  // a miss returns the code point unchanged
                  res_cp_in = req_code_point;
                  if (n_used != '0) begin
                     lo_in    = '0;
                     hi_in    = n_used;
                     mid_in   = ADDR_W'(n_used >> 1);
                     rd_en    = 1'b1;
                     rd_addr  = ADDR_W'(n_used >> 1);
                     state_in = ucrm_pkg::ST_SEARCH;
                  end
               end
            end
         end

         ucrm_pkg::ST_SEARCH: begin
            if (entry_hit) begin
               state_in = ucrm_pkg::ST_MAP;
            end else if (next_lo < next_hi) begin
               lo_in   = next_lo;
               hi_in   = next_hi;
               mid_in  = ADDR_W'(next_sum[CNT_W:1]);
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(next_sum[CNT_W:1]);
            end else begin
               state_in = ucrm_pkg::ST_DONE;
            end
         end

         ucrm_pkg::ST_MAP: begin
            res_hit_in = 1'b1;
            res_cp_in  = cp_ff;
            res_err_in = 1'b0;
            if (rd_data_ff.alternating_run) begin
               if (alt_res > {1'b0, ucrm_pkg::MAX_CP}) begin
                  res_err_in = 1'b1;
               end else begin
                  res_cp_in = alt_res[CP_W-1:0];
               end
            end else begin
               if (delta_res[CP_W+2] || (delta_res[CP_W+1:0] > {2'b00, ucrm_pkg::MAX_CP}))
               begin
                  res_err_in = 1'b1;
               end else begin
                  res_cp_in = delta_res[CP_W-1:0];
               end
            end
            state_in = ucrm_pkg::ST_DONE;
         end

         ucrm_pkg::ST_DONE: begin
            // move the result into the output register when it is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_cp_in    = res_cp_ff;
               rsp_hit_in   = res_hit_ff;
               rsp_bad_in   = res_bad_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ucrm_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ucrm_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ucrm_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            entry_count_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      cp_ff      <= cp_in;
      cs_ff      <= cs_in;
      res_cp_ff  <= res_cp_in;
      res_hit_ff <= res_hit_in;
      res_bad_ff <= res_bad_in;
      res_err_ff <= res_err_in;
      rsp_cp_ff  <= rsp_cp_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_bad_ff <= rsp_bad_in;
      rsp_err_ff <= rsp_err_in;
   end

   // Table memory: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // An invalid case selector goes straight to a flagged result
   a_bad_case_direct: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_action == ucrm_pkg::ACTION_QUERY &&
       req_case_select == ucrm_pkg::CASE_INVALID)
      |=> (state_ff == ucrm_pkg::ST_DONE && res_bad_ff && !res_hit_ff))
      else $error("invalid case did not yield a flagged result");

   // Search window stays nonempty and the probe lies inside it
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ucrm_pkg::ST_SEARCH)
      |-> (lo_ff < hi_ff && CNT_W'(mid_ff) >= lo_ff && CNT_W'(mid_ff) < hi_ff))
      else $error("binary search window corrupt");

   // A range error only comes from a hit
   a_err_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_err_ff || rsp_hit_ff))
      else $error("range error without a range hit");

   // A finished result reaches the output register when it is free
   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ucrm_pkg::ST_DONE && rsp_free)
      |=> (rsp_valid_ff && state_ff == ucrm_pkg::ST_IDLE))
      else $error("finished result not moved to the output");

endmodule

/* sim/unicode_case_range_mapper_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unicode_case_range_mapper_test
// Self-checking bench for the case-range mapper. Loads sorted case-range
// tables, runs directed and random queries through the request channel and
// compares each response against a shadow table and a local lookup routine.
// Both channels idle at random but in one random-traffic phase; one stretch holds off the response side.
// ---------------------------------------------------------------------------
module unicode_case_range_mapper_test;

   localparam int CP_W    = ucrm_pkg::CP_W;
   localparam int DELTA_W = ucrm_pkg::DELTA_W;
   localparam int INDEX_W = ucrm_pkg::INDEX_W;
   localparam int CASE_W  = ucrm_pkg::CASE_W;
   localparam int COUNT_W = ucrm_pkg::COUNT_W;

   localparam int TABLE_DEPTH    = 512;
   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 5;
   localparam int DELTA_MAX      = 1114111;
   localparam int FIRST_TABLE_CP = 'h80;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 20;
   localparam int QUIET_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 10;
   localparam int IDLE_PERCENT   = 25;
   localparam int PHASE_ITEMS    = 80;

   typedef struct {
      logic                      action;
      logic [INDEX_W-1:0]        entry_index;
      logic [CP_W-1:0]           range_low;
      logic [CP_W-1:0]           range_high;
      logic signed [DELTA_W-1:0] delta_upper;
      logic signed [DELTA_W-1:0] delta_lower;
      logic signed [DELTA_W-1:0] delta_title;
      logic                      alternating_run;
      logic [CP_W-1:0]           code_point;
      logic [CASE_W-1:0]         case_select;
   } mapper_item_type;

   typedef struct {
      logic [CP_W-1:0] mapped;
      logic            hit;
      logic            bad_case;
      logic            range_error;
   } mapper_result_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_wr_en;
   logic [COUNT_W-1:0]        csr_wr_data;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_action;
   logic [INDEX_W-1:0]        req_entry_index;
   logic [CP_W-1:0]           req_range_low;
   logic [CP_W-1:0]           req_range_high;
   logic signed [DELTA_W-1:0] req_delta_upper;
   logic signed [DELTA_W-1:0] req_delta_lower;
   logic signed [DELTA_W-1:0] req_delta_title;
   logic                      req_alternating_run;
   logic [CP_W-1:0]           req_code_point;
   logic [CASE_W-1:0]         req_case_select;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [CP_W-1:0]           rsp_mapped_code_point;
   logic                      rsp_range_hit;
   logic                      rsp_bad_case;
   logic                      rsp_range_error;

   // Shadow copy of the case table and the entry count register
   ucrm_pkg::entry_type shadow_ranges [TABLE_DEPTH];
   int unsigned         shadow_count;
   mapper_result_type   expected_maps [$];

   bit          idling_on = 1'b1;
   logic        rsp_hold  = 1'b0;
   event        hold_kick;
   int unsigned mismatch_count;
   int unsigned quiet_cycles;

   unicode_case_range_mapper #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_entry_index(req_entry_index),
      .req_range_low(req_range_low),
      .req_range_high(req_range_high),
      .req_delta_upper(req_delta_upper),
      .req_delta_lower(req_delta_lower),
      .req_delta_title(req_delta_title),
      .req_alternating_run(req_alternating_run),
      .req_code_point(req_code_point),
      .req_case_select(req_case_select),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_mapped_code_point(rsp_mapped_code_point),
      .rsp_range_hit(rsp_range_hit),
      .rsp_bad_case(rsp_bad_case),
      .rsp_range_error(rsp_range_error)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Map one code point the way the block should, using the shadow table
   function automatic mapper_result_type predict_mapping(input logic [CP_W-1:0] cp,
                                                         input logic [CASE_W-1:0] cs);
      mapper_result_type         r;
      int unsigned               n;
      int unsigned               lo;
      int unsigned               hi;
      int unsigned               mid;
      ucrm_pkg::entry_type       e;
      logic signed [DELTA_W-1:0] d;
      longint                    offset;
      longint                    sum;
      logic                      found;
      r = '{default: '0};
      if (cs == ucrm_pkg::CASE_INVALID) begin
         r.mapped   = ucrm_pkg::REPL_CHAR;
         r.bad_case = 1'b1;
      end else if (cp <= ucrm_pkg::ASCII_MAX) begin
         if (cs == ucrm_pkg::CASE_LOWER) begin
            if (cp >= ucrm_pkg::CHAR_UPPER_A && cp <= ucrm_pkg::CHAR_UPPER_Z)
               cp = cp + ucrm_pkg::ASCII_SHIFT;
         end else if (cp >= ucrm_pkg::CHAR_LOWER_A && cp <= ucrm_pkg::CHAR_LOWER_Z) begin
            cp = cp - ucrm_pkg::ASCII_SHIFT;
         end
         r.mapped = cp;
      end else begin
         n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
         lo = 0;
         hi = n;
         found = 1'b0;
         r.mapped = cp;
         // Binary search over the entries in use
         while (lo < hi && !found) begin
            mid = lo + (hi - lo) / 2;
            e = shadow_ranges[mid];
            if (e.range_low <= cp && cp <= e.range_high) begin
               found = 1'b1;
               r.hit = 1'b1;
               if (e.alternating_run) begin
                  offset = longint'(cp) - longint'(e.range_low);
                  sum = longint'(e.range_low) + ((offset & ~longint'(1)) | longint'(cs[0]));
               end else begin
                  case (cs)
                     ucrm_pkg::CASE_UPPER: d = e.delta_upper;
                     ucrm_pkg::CASE_LOWER: d = e.delta_lower;
                     default:              d = e.delta_title;
                  endcase
                  sum = longint'(cp) + longint'(d);
               end
               if (sum < 0 || sum > longint'(ucrm_pkg::MAX_CP)) r.range_error = 1'b1;
               else r.mapped = sum[CP_W-1:0];
            end else if (cp < e.range_low) begin
               hi = mid;
            end else begin
               lo = mid + 1;
            end
         end
      end
      return r;
   endfunction

   function automatic logic signed [DELTA_W-1:0] pick_delta();
      case ($urandom_range(0, 9))
         0:       return DELTA_W'(int'($urandom_range(0, 2 * DELTA_MAX)) - DELTA_MAX);
         1:       return DELTA_W'(DELTA_MAX);
         2:       return DELTA_W'(-DELTA_MAX);
         default: return DELTA_W'(int'($urandom_range(0, 160)) - 80);
      endcase
   endfunction

   // Random item with every field in range; callers overwrite what matters
   function automatic mapper_item_type random_item();
      mapper_item_type it;
      it.action          = 1'($urandom_range(0, 1));
      it.entry_index     = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
      it.range_low       = CP_W'($urandom_range(0, ucrm_pkg::MAX_CP));
      it.range_high      = CP_W'($urandom_range(0, ucrm_pkg::MAX_CP));
      it.delta_upper     = pick_delta();
      it.delta_lower     = pick_delta();
      it.delta_title     = pick_delta();
      it.alternating_run = 1'($urandom_range(0, 1));
      it.code_point      = CP_W'($urandom_range(0, ucrm_pkg::MAX_CP));
      it.case_select     = CASE_W'($urandom_range(0, 3));
      return it;
   endfunction

   function automatic mapper_item_type load_entry(input int idx, input int lo, input int hi,
                                                  input int du, input int dl, input int dt,
                                                  input logic alt);
      mapper_item_type it;
      it = random_item();
      it.action          = ucrm_pkg::ACTION_LOAD;
      it.entry_index     = INDEX_W'(idx);
      it.range_low       = CP_W'(lo);
      it.range_high      = CP_W'(hi);
      it.delta_upper     = DELTA_W'(du);
      it.delta_lower     = DELTA_W'(dl);
      it.delta_title     = DELTA_W'(dt);
      it.alternating_run = alt;
      return it;
   endfunction

   function automatic mapper_item_type query_item(input int cp, input logic [CASE_W-1:0] cs);
      mapper_item_type it;
      it = random_item();
      it.action      = ucrm_pkg::ACTION_QUERY;
      it.code_point  = CP_W'(cp);
      it.case_select = cs;
      return it;
   endfunction

   // Query biased toward hits in the first n entries, plus edges, ASCII and noise
   function automatic mapper_item_type pick_query(input int unsigned n);
      mapper_item_type     it;
      ucrm_pkg::entry_type e;
      int unsigned         roll;
      it = random_item();
      it.action = ucrm_pkg::ACTION_QUERY;
      roll = $urandom_range(0, 99);
      e = shadow_ranges[(n > 0) ? $urandom_range(0, n - 1) : 0];
      if (n > 0 && roll < 60) begin
         if (e.range_low <= e.range_high)
            it.code_point = CP_W'($urandom_range(e.range_low, e.range_high));
         else
            it.code_point = e.range_low;
      end else if (n > 0 && roll < 70) begin
         it.code_point = roll[0] ? e.range_low - 1'b1 : e.range_high + 1'b1;
      end else if (roll < 80) begin
         it.code_point = CP_W'($urandom_range(0, ucrm_pkg::ASCII_MAX));
      end
      it.case_select = ($urandom_range(0, 99) < 10) ? ucrm_pkg::CASE_INVALID
                                                    : CASE_W'($urandom_range(0, 2));
      return it;
   endfunction

   // Predict the response, then drive one transfer and wait until it is taken
   task automatic send_item(input mapper_item_type it);
      if (it.action == ucrm_pkg::ACTION_LOAD) begin
         shadow_ranges[it.entry_index].range_low       = it.range_low;
         shadow_ranges[it.entry_index].range_high      = it.range_high;
         shadow_ranges[it.entry_index].delta_upper     = it.delta_upper;
         shadow_ranges[it.entry_index].delta_lower     = it.delta_lower;
         shadow_ranges[it.entry_index].delta_title     = it.delta_title;
         shadow_ranges[it.entry_index].alternating_run = it.alternating_run;
         expected_maps.push_back('{default: '0});
      end else begin
         expected_maps.push_back(predict_mapping(it.code_point, it.case_select));
      end
      while (idling_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_action          <= it.action;
      req_entry_index     <= it.entry_index;
      req_range_low       <= it.range_low;
      req_range_high      <= it.range_high;
      req_delta_upper     <= it.delta_upper;
      req_delta_lower     <= it.delta_lower;
      req_delta_title     <= it.delta_title;
      req_alternating_run <= it.alternating_run;
      req_code_point      <= it.code_point;
      req_case_select     <= it.case_select;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and drain every outstanding response
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_maps.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry_count(input int unsigned count);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_W'(count);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_count = count & ((1 << COUNT_W) - 1);
   endtask

   // Load n sorted, non-overlapping ranges above ASCII into slots 0..n-1
   task automatic fill_case_table(input int n);
      int stride;
      int base;
      int lo;
      int hi;
      int span;
      int swap;
      mapper_item_type it;
      if (n > 0) begin
         stride = (int'(ucrm_pkg::MAX_CP) - FIRST_TABLE_CP + 1) / n;
         for (int i = 0; i < n; i++) begin
            base = FIRST_TABLE_CP + i * stride;
            lo = base + int'($urandom_range(0, stride / 2));
            span = base + stride - 1 - lo;
            hi = lo + int'($urandom_range(0, 1) ? $urandom_range(0, (span < 64) ? span : 64)
                                                : $urandom_range(0, span));
            if (i == n - 1 && $urandom_range(0, 3) == 0) hi = int'(ucrm_pkg::MAX_CP);
            // Now and then store an inverted entry
            if ($urandom_range(0, 39) == 0) begin
               swap = lo;
               lo = hi;
               hi = swap;
            end
            it = load_entry(i, lo, hi, int'(pick_delta()), int'(pick_delta()),
                            int'(pick_delta()), $urandom_range(0, 99) < 30);
            send_item(it);
         end
      end
   endtask

   // Hold off the response side for a long stretch
   always begin
      @(hold_kick);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Check each response transfer, then pick the next stall value
   always @(posedge clock) begin
      mapper_result_type want;
      if (rsp_valid && !rsp_stall) begin
         if (expected_maps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: cp=%h hit=%b bad=%b err=%b",
                        rsp_mapped_code_point, rsp_range_hit, rsp_bad_case,
                        rsp_range_error);
         end else begin
            want = expected_maps.pop_front();
            if (want.mapped != rsp_mapped_code_point || want.hit != rsp_range_hit ||
                want.bad_case != rsp_bad_case || want.range_error != rsp_range_error) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected cp=%h hit=%b bad=%b err=%b",
                           want.mapped, want.hit, want.bad_case, want.range_error,
                           ", got cp=%h hit=%b bad=%b err=%b",
                           rsp_mapped_code_point, rsp_range_hit, rsp_bad_case,
                           rsp_range_error);
            end
         end
      end
      rsp_stall <= rsp_hold || (idling_on && $urandom_range(0, 99) < IDLE_PERCENT);
   end

   // Abort when no transfer happens on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Empty table: everything above ASCII misses
   task automatic test_reset_state();
      send_item(query_item('h3B1, ucrm_pkg::CASE_UPPER));
      send_item(query_item('h10FFFF, ucrm_pkg::CASE_TITLE));
      send_item(query_item('h61, ucrm_pkg::CASE_UPPER));
      wait_idle();
   endtask

   task automatic test_directed_cases();
      send_item(load_entry(0, 'h100, 'h12F, 0, 0, 0, 1'b1));
      send_item(load_entry(1, 'h391, 'h3A9, 0, 32, 0, 1'b0));
      send_item(load_entry(2, 'h3B1, 'h3C9, -32, 0, -32, 1'b0));
      send_item(load_entry(3, 'h2000, 'h2000, DELTA_MAX, -DELTA_MAX, 0, 1'b0));
      send_item(load_entry(4, 'h5000, 'h4000, 1, 1, 1, 1'b0));
      send_item(load_entry(5, 'h10FF01, 'h10FFFF, 0, 0, 0, 1'b1));
      wait_idle();
      write_entry_count(6);
      // Invalid case wins over everything, even above the code point range
      send_item(query_item('h1FFFFF, ucrm_pkg::CASE_INVALID));
      send_item(query_item('h1FFFFF, ucrm_pkg::CASE_UPPER));
      // ASCII shortcut at the letter bounds
      send_item(query_item(int'(ucrm_pkg::CHAR_LOWER_A), ucrm_pkg::CASE_UPPER));
      send_item(query_item(int'(ucrm_pkg::CHAR_LOWER_Z), ucrm_pkg::CASE_TITLE));
      send_item(query_item(int'(ucrm_pkg::CHAR_UPPER_A), ucrm_pkg::CASE_LOWER));
      send_item(query_item(int'(ucrm_pkg::CHAR_UPPER_Z), ucrm_pkg::CASE_LOWER));
      send_item(query_item(int'(ucrm_pkg::CHAR_LOWER_A), ucrm_pkg::CASE_LOWER));
      send_item(query_item(int'(ucrm_pkg::ASCII_MAX), ucrm_pkg::CASE_UPPER));
      send_item(query_item(0, ucrm_pkg::CASE_LOWER));
      // Alternating run and plain deltas
      send_item(query_item('h100, ucrm_pkg::CASE_LOWER));
      send_item(query_item('h12F, ucrm_pkg::CASE_UPPER));
      send_item(query_item('h391, ucrm_pkg::CASE_LOWER));
      send_item(query_item('h3A9, ucrm_pkg::CASE_TITLE));
      send_item(query_item('h3C9, ucrm_pkg::CASE_UPPER));
      // Sums out of range on both sides
      send_item(query_item('h2000, ucrm_pkg::CASE_UPPER));
      send_item(query_item('h2000, ucrm_pkg::CASE_LOWER));
      send_item(query_item('h2000, ucrm_pkg::CASE_TITLE));
      // Inverted entry never hits; the alternating run at the top stays in range
      send_item(query_item('h4800, ucrm_pkg::CASE_UPPER));
      send_item(query_item('h10FFFF, ucrm_pkg::CASE_LOWER));
      send_item(query_item('h10FFFE, ucrm_pkg::CASE_UPPER));
      send_item(query_item('h80, ucrm_pkg::CASE_TITLE));
      wait_idle();
   endtask

   // Keep offering queries while the response side is held off
   task automatic test_output_backpressure();
      -> hold_kick;
      repeat (12) send_item(pick_query(shadow_count));
      wait_idle();
   endtask

   task automatic test_full_table();
      fill_case_table(TABLE_DEPTH);
      wait_idle();
      write_entry_count(TABLE_DEPTH);
      repeat (PHASE_ITEMS) send_item(pick_query(TABLE_DEPTH));
      wait_idle();
      // Count beyond the depth saturates
      write_entry_count((1 << COUNT_W) - 1);
      repeat (PHASE_ITEMS) send_item(pick_query(TABLE_DEPTH));
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int unsigned     phase_counts [10];
      int unsigned     n;
      mapper_item_type it;
      phase_counts = '{0, 1, 2, 3, 16, 100, 64, 0, 0, (1 << COUNT_W) - 1};
      phase_counts[7] = $urandom_range(4, 60);
      phase_counts[8] = $urandom_range(4, 60);
      for (int p = 0; p < 10; p++) begin
         n = (phase_counts[p] > TABLE_DEPTH) ? TABLE_DEPTH : phase_counts[p];
         // The saturated phase searches whatever the table holds by now
         if (phase_counts[p] <= TABLE_DEPTH) begin
            fill_case_table(n);
            wait_idle();
         end
         write_entry_count(phase_counts[p]);
         idling_on = (p != 4);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 15) begin
               it = random_item();
               it.action = ucrm_pkg::ACTION_LOAD;
            end else begin
               it = pick_query(n);
            end
            send_item(it);
         end
         wait_idle();
         idling_on = 1'b1;
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_valid           = 1'b0;
      req_action          = ucrm_pkg::ACTION_LOAD;
      req_entry_index     = '0;
      req_range_low       = '0;
      req_range_high      = '0;
      req_delta_upper     = '0;
      req_delta_lower     = '0;
      req_delta_title     = '0;
      req_alternating_run = 1'b0;
      req_code_point      = '0;
      req_case_select     = ucrm_pkg::CASE_UPPER;
      shadow_count        = 0;
      mismatch_count      = 0;
      quiet_cycles        = 0;
      foreach (shadow_ranges[i]) shadow_ranges[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_directed_cases();
      test_output_backpressure();
      test_full_table();
      test_random_traffic();

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

/* unicode_case_range_mapper.f */
rtl/core/ucrm_pkg.sv
rtl/core/unicode_case_range_mapper.sv
sim/unicode_case_range_mapper_test.sv
